// File: rtl/core/bsf_pkg.sv
// ----------------------------------------------------------------------------
// bsf_pkg
// Shared types and constants for the binary substring finder.
// ----------------------------------------------------------------------------
package bsf_pkg;

  localparam int PATTERN_MAX   = 64;
  localparam int POSITION_BITS = 16;
  localparam int LEN_W         = $clog2(PATTERN_MAX + 1);
  localparam int OFFSET_W      = 16;
  localparam int BYTE_W        = 8;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_DATA   = 2'd2
  } cmd_t;

  typedef logic [PATTERN_MAX-1:0][BYTE_W-1:0] bytes_t;

  // decoded word presented to the pattern and search logic
  typedef struct packed {
    logic              clear;
    logic              append;
    logic              data;
    logic              last;
    logic [BYTE_W-1:0] value;
  } op_t;

  typedef struct packed {
    logic                found;
    logic [OFFSET_W-1:0] offset;
    logic                overflow;
  } res_t;

endpackage

// File: rtl/core/bsf_pattern_reg.sv
// ----------------------------------------------------------------------------
// bsf_pattern_reg
// Pattern held newest-first in a shift register, with a thermometer mask
// of valid positions and the pattern length.
// ----------------------------------------------------------------------------
module bsf_pattern_reg import bsf_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  op_t              op,
  output bytes_t           pat,
  output logic [PATTERN_MAX-1:0] mask,
  output logic [LEN_W-1:0] len
);

  logic full;

  assign full = mask[PATTERN_MAX-1];

  always_ff @(posedge clk) begin
    if (advance && op.append && !full) begin
      pat[0] <= op.value;
      for (int j = 1; j < PATTERN_MAX; j++) begin
        pat[j] <= pat[j-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= '0;
      len  <= '0;
    end else if (advance) begin
      if (op.clear) begin
        mask <= '0;
        len  <= '0;
      end else if (op.append && !full) begin
        mask[0] <= 1'b1;
        for (int j = 1; j < PATTERN_MAX; j++) begin
          mask[j] <= mask[j-1];
        end
        len <= len + LEN_W'(1);
      end
    end
  end

endmodule

// File: rtl/core/bsf_search.sv
// ----------------------------------------------------------------------------
// bsf_search
// Data window, position counter and parallel window compare. Produces the
// result for the word in flight and updates search state on advance.
// ----------------------------------------------------------------------------
module bsf_search import bsf_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   advance,
  input  op_t                    op,
  input  bytes_t                 pat,
  input  logic [PATTERN_MAX-1:0] mask,
  input  logic [LEN_W-1:0]       len,
  output logic                   res_valid,
  output res_t                   res
);

  bytes_t                   window;
  bytes_t                   win_next;
  logic [POSITION_BITS-1:0] bytes_seen;
  logic                     match_done;
  logic                     position_overflow;

  logic                     at_limit;
  logic                     ovf_next;
  logic [POSITION_BITS:0]   pos1;
  logic [POSITION_BITS:0]   diff;
  logic                     enough;
  logic [PATTERN_MAX-1:0]   eq;
  logic                     hit;
  logic                     live;

  assign live     = op.data && !match_done;
  assign at_limit = &bytes_seen;
  assign ovf_next = position_overflow || at_limit;
  assign pos1     = {1'b0, bytes_seen} + (POSITION_BITS+1)'(1);
  assign diff     = pos1 - (POSITION_BITS+1)'(len);
  assign enough   = ovf_next || (pos1 >= (POSITION_BITS+1)'(len));

  always_comb begin
    win_next[0] = op.value;
    for (int j = 1; j < PATTERN_MAX; j++) begin
      win_next[j] = window[j-1];
    end
    for (int j = 0; j < PATTERN_MAX; j++) begin
      eq[j] = !mask[j] || (pat[j] == win_next[j]);
    end
  end

  assign hit = live && enough && mask[0] && (&eq);

  always_comb begin
    res_valid    = live && (hit || op.last);
    res.found    = hit;
    res.overflow = ovf_next;
    if (!hit) begin
      res.offset = '0;
    end else if (ovf_next) begin
      res.offset = '1;
    end else begin
      res.offset = OFFSET_W'(diff[POSITION_BITS-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (advance && live) begin
      window <= win_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_seen        <= '0;
      match_done        <= 1'b0;
      position_overflow <= 1'b0;
    end else if (advance) begin
      if (op.clear || op.append || (op.data && op.last)) begin
        bytes_seen        <= '0;
        match_done        <= 1'b0;
        position_overflow <= 1'b0;
      end else if (live) begin
        if (!at_limit) begin
          bytes_seen <= bytes_seen + POSITION_BITS'(1);
        end
        position_overflow <= ovf_next;
        match_done        <= hit;
      end
    end
  end

endmodule

// File: rtl/core/binary_substring_finder_unit.sv
// ----------------------------------------------------------------------------
// binary_substring_finder_unit
// An accepted word loads the input register; its result, if it has one, loads the
// result register when the word advances. Throughput: one word per cycle while the
// result slot is free or being taken, set by the combinational parallel compare of all window positions.
// Reset (synchronous): pattern empty, search restarted, no word held.
// ----------------------------------------------------------------------------
module binary_substring_finder_unit import bsf_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          cmd,
  input  logic [BYTE_W-1:0]   byte_value,
  input  logic                is_last,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                found,
  output logic [OFFSET_W-1:0] match_offset,
  output logic                overflow
);

  logic                   s1_valid;
  logic [1:0]             s1_cmd;
  logic [BYTE_W-1:0]      s1_value;
  logic                   s1_last;
  op_t                    op;
  logic                   advance;
  logic                   res_valid;
  res_t                   res;
  bytes_t                 pat;
  logic [PATTERN_MAX-1:0] mask;
  logic [LEN_W-1:0]       len;

  assign op.clear  = s1_cmd == CMD_CLEAR;
  assign op.append = s1_cmd == CMD_APPEND;
  assign op.data   = s1_cmd == CMD_DATA;
  assign op.last   = s1_last;
  assign op.value  = s1_value;

  assign advance  = s1_valid && (!res_valid || !out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_cmd   <= cmd;
      s1_value <= byte_value;
      s1_last  <= is_last;
    end
    if (advance && res_valid) begin
      found        <= res.found;
      match_offset <= res.offset;
      overflow     <= res.overflow;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid <= in_valid;
      end
      if (advance && res_valid) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  bsf_pattern_reg u_pattern (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .op      (op),
    .pat     (pat),
    .mask    (mask),
    .len     (len)
  );

  bsf_search u_search (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .op        (op),
    .pat       (pat),
    .mask      (mask),
    .len       (len),
    .res_valid (res_valid),
    .res       (res)
  );

  a_found_needs_pattern: assert property (@(posedge clk) disable iff (rst)
    (advance && res_valid && res.found) |-> (len != '0))
    else $error("match reported with empty pattern");

  a_result_from_data: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && res_valid) |-> (s1_cmd == CMD_DATA))
    else $error("result raised by a non-data word");

  a_miss_offset_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !found) |-> (match_offset == '0))
    else $error("not-found result carries nonzero offset");

  a_no_stall_when_free: assert property (@(posedge clk) disable iff (rst)
    (!out_valid || out_ready) |-> in_ready)
    else $error("input stalled with free result slot");

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for binary_substring_finder_unit. An initial block fills
// a queue with words (directed corner cases, well-formed pattern and buffer
// sequences with planted matches, and noise). A clocked driver presents them
// with random gaps, a predictor works out each result at acceptance, and a
// clocked monitor checks every result word against the oldest expected one
// under random back-pressure.
// ----------------------------------------------------------------------------
module tb import bsf_pkg::*; ();

  localparam logic [1:0]      CMD_UNUSED = 2'd3;
  localparam longint unsigned POS_MAX    = (64'd1 << POSITION_BITS) - 1;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [BYTE_W-1:0] value;
    logic              last;
  } stim_word_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [1:0]          cmd = '0;
  logic [BYTE_W-1:0]   byte_value = '0;
  logic                is_last = 1'b0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic                found;
  logic [OFFSET_W-1:0] match_offset;
  logic                overflow;

  binary_substring_finder_unit dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .cmd(cmd),
    .byte_value(byte_value),
    .is_last(is_last),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .found(found),
    .match_offset(match_offset),
    .overflow(overflow)
  );

  always #6 clk = ~clk;

  stim_word_t pending_words [$];
  res_t       awaited_reports [$];
  int         mismatches = 0;

  // predictor state
  logic [BYTE_W-1:0] pattern_bytes [PATTERN_MAX] = '{default: '0};
  int unsigned       pattern_len = 0;
  logic [BYTE_W-1:0] recent_bytes [PATTERN_MAX] = '{default: '0};
  longint unsigned   bytes_taken = 0;
  bit                hit_done = 1'b0;
  bit                pos_sat = 1'b0;

  function automatic void restart_search();
    foreach (recent_bytes[k]) recent_bytes[k] = '0;
    bytes_taken = 0;
    hit_done = 1'b0;
    pos_sat = 1'b0;
  endfunction

  function automatic void predict_search(input stim_word_t w, output bit emit,
                                         output res_t rep);
    longint unsigned idx;
    bit              enough;
    bit              equal;
    emit = 1'b0;
    rep = '0;
    case (w.cmd)
      CMD_CLEAR: begin
        pattern_len = 0;
        restart_search();
      end
      CMD_APPEND: begin
        if (pattern_len < PATTERN_MAX) begin
          pattern_bytes[pattern_len] = w.value;
          pattern_len++;
        end
        restart_search();
      end
      CMD_DATA: begin
        if (hit_done) begin
          if (w.last) restart_search();
        end else begin
          for (int k = PATTERN_MAX - 1; k > 0; k--) recent_bytes[k] = recent_bytes[k-1];
          recent_bytes[0] = w.value;
          idx = bytes_taken;
          if (bytes_taken >= POS_MAX) pos_sat = 1'b1;
          else bytes_taken++;
          enough = pos_sat || (idx + 1 >= pattern_len);
          equal = (pattern_len != 0);
          for (int k = 0; k < pattern_len; k++) begin
            if (pattern_bytes[k] != recent_bytes[pattern_len-1-k]) equal = 1'b0;
          end
          if (enough && equal) begin
            emit = 1'b1;
            rep.found = 1'b1;
            rep.offset = OFFSET_W'(pos_sat ? POS_MAX : idx + 1 - pattern_len);
            rep.overflow = pos_sat;
            if (w.last) restart_search();
            else hit_done = 1'b1;
          end else if (w.last) begin
            emit = 1'b1;
            rep.found = 1'b0;
            rep.offset = '0;
            rep.overflow = pos_sat;
            restart_search();
          end
        end
      end
      default: ;
    endcase
  endfunction

  function automatic int draw_wait(inout bit calm);
    if ($urandom_range(0, 39) == 0) calm = !calm;
    return calm ? 0 : int'($urandom_range(0, 3));
  endfunction

  // driver
  stim_word_t cur_word;
  int         send_gap = 0;
  bit         send_calm = 1'b0;

  always @(posedge clk) begin : drive_words
    bit   emit;
    res_t rep;
    logic next_valid;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      next_valid = in_valid;
      if (in_valid && in_ready) begin
        predict_search(cur_word, emit, rep);
        if (emit) awaited_reports.push_back(rep);
        next_valid = 1'b0;
      end
      if (!next_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_words.size() != 0) begin
          cur_word = pending_words.pop_front();
          cmd <= cur_word.cmd;
          byte_value <= cur_word.value;
          is_last <= cur_word.last;
          next_valid = 1'b1;
          send_gap = draw_wait(send_calm);
        end
      end
      in_valid <= next_valid;
    end
  end

  // monitor
  int recv_gap = 0;
  bit recv_calm = 1'b0;

  always @(posedge clk) begin : check_reports
    res_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (awaited_reports.size() == 0) begin
          $error("unexpected result: found=%0d match_offset=%0d overflow=%0d",
                 found, match_offset, overflow);
          mismatches++;
        end else begin
          want = awaited_reports.pop_front();
          if (found !== want.found) begin
            $error("found: expected %0d, got %0d", want.found, found);
            mismatches++;
          end
          if (match_offset !== want.offset) begin
            $error("match_offset: expected %0d, got %0d", want.offset, match_offset);
            mismatches++;
          end
          if (overflow !== want.overflow) begin
            $error("overflow: expected %0d, got %0d", want.overflow, overflow);
            mismatches++;
          end
        end
        recv_gap = draw_wait(recv_calm);
      end else if (recv_gap > 0) begin
        recv_gap--;
      end
      out_ready <= (recv_gap == 0);
    end
  end

  // stimulus generation
  logic [BYTE_W-1:0] gen_pat [$];
  logic [BYTE_W-1:0] alphabet [2];
  int                stim_count = 0;

  task automatic add_word(input logic [1:0] c, input logic [BYTE_W-1:0] v, input bit l);
    stim_word_t w;
    w.cmd = c;
    w.value = v;
    w.last = l;
    pending_words.push_back(w);
    if (c != CMD_UNUSED) stim_count++;
  endtask

  function automatic logic [BYTE_W-1:0] pick_byte();
    if ($urandom_range(0, 19) < 17) return alphabet[$urandom_range(0, 1)];
    return BYTE_W'($urandom_range(0, 255));
  endfunction

  task automatic new_pattern(input int len);
    logic [BYTE_W-1:0] b;
    add_word(CMD_CLEAR, BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    gen_pat.delete();
    for (int k = 0; k < len; k++) begin
      b = pick_byte();
      add_word(CMD_APPEND, b, 1'($urandom_range(0, 1)));
      if (gen_pat.size() < PATTERN_MAX) gen_pat.push_back(b);
    end
  endtask

  task automatic send_buffer(input int n, input bit plant);
    logic [BYTE_W-1:0] stream [$];
    int                pos;
    for (int k = 0; k < n; k++) stream.push_back(pick_byte());
    if (plant && gen_pat.size() != 0 && n >= gen_pat.size()) begin
      pos = $urandom_range(0, n - gen_pat.size());
      for (int k = 0; k < gen_pat.size(); k++) stream[pos + k] = gen_pat[k];
    end
    for (int k = 0; k < n; k++) add_word(CMD_DATA, stream[k], k == n - 1);
  endtask

  function automatic int draw_pattern_len();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 0;
    if (r < 15) return $urandom_range(1, 4);
    if (r < 19) return $urandom_range(5, 20);
    return $urandom_range(PATTERN_MAX - 2, PATTERN_MAX + 2);
  endfunction

  initial begin : stimulus
    int start_count;
    int choice;
    int n;

    // empty pattern, unused command
    add_word(CMD_DATA, 8'hFF, 1'b1);
    add_word(CMD_UNUSED, 8'hFF, 1'b1);
    add_word(CMD_CLEAR, 8'hAA, 1'b1);
    add_word(CMD_APPEND, 8'h00, 1'b0);
    add_word(CMD_APPEND, 8'hFF, 1'b1);
    // short buffer
    add_word(CMD_DATA, 8'h00, 1'b1);
    // match at offset 1, rest of buffer ignored
    add_word(CMD_DATA, 8'h7E, 1'b0);
    add_word(CMD_DATA, 8'h00, 1'b0);
    add_word(CMD_DATA, 8'hFF, 1'b0);
    add_word(CMD_DATA, 8'h00, 1'b0);
    add_word(CMD_DATA, 8'hFF, 1'b1);
    // append mid-buffer restarts the search
    add_word(CMD_DATA, 8'h00, 1'b0);
    add_word(CMD_APPEND, 8'h01, 1'b0);
    add_word(CMD_DATA, 8'hFF, 1'b0);
    add_word(CMD_DATA, 8'h01, 1'b1);
    add_word(CMD_DATA, 8'h00, 1'b0);
    add_word(CMD_DATA, 8'hFF, 1'b0);
    add_word(CMD_DATA, 8'h01, 1'b1);
    // zero pattern against the cleared window
    add_word(CMD_CLEAR, 8'h00, 1'b0);
    add_word(CMD_APPEND, 8'h00, 1'b0);
    add_word(CMD_APPEND, 8'h00, 1'b0);
    add_word(CMD_DATA, 8'h00, 1'b1);
    add_word(CMD_DATA, 8'h00, 1'b0);
    add_word(CMD_DATA, 8'h00, 1'b1);

    // full pattern, extra appends dropped
    alphabet[0] = BYTE_W'($urandom_range(0, 255));
    alphabet[1] = BYTE_W'($urandom_range(0, 255));
    new_pattern(PATTERN_MAX + 2);
    send_buffer(PATTERN_MAX + 6, 1'b1);

    start_count = stim_count;
    while (stim_count - start_count < 740) begin
      choice = $urandom_range(0, 9);
      if (choice < 7) begin
        n = $urandom_range(0, 4);
        if (n < 3) begin
          alphabet[0] = BYTE_W'($urandom_range(0, 255));
          alphabet[1] = BYTE_W'($urandom_range(0, 255));
          new_pattern(draw_pattern_len());
        end else if (n == 3 && gen_pat.size() < PATTERN_MAX) begin
          gen_pat.push_back(pick_byte());
          add_word(CMD_APPEND, gen_pat[$], 1'($urandom_range(0, 1)));
        end
        repeat ($urandom_range(1, 3)) begin
          if ($urandom_range(0, 4) == 0) n = $urandom_range(1, 3);
          else n = gen_pat.size() + $urandom_range(0, 6);
          if (n == 0) n = 1;
          send_buffer(n, $urandom_range(0, 9) < 6);
        end
      end else begin
        repeat ($urandom_range(1, 6))
          add_word(2'($urandom_range(0, 3)), BYTE_W'($urandom_range(0, 255)),
                   1'($urandom_range(0, 1)));
      end
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    while (pending_words.size() != 0 || in_valid) @(posedge clk);
    while (awaited_reports.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && awaited_reports.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #(12 * 3_000_000);
    $display("TB_ERROR");
    $finish;
  end

endmodule
